@@ rtl/sce_pkg.sv @@
// Shared types, constants and a helper function for the spinal code encoder.
package sce_pkg;

    localparam int SYMBOLS_PER_CHUNK = 8;
    localparam int SYMBOL_SLOTS      = 8;
    localparam int SYM_IDX_W         = $clog2(SYMBOL_SLOTS);
    localparam int BPC_W             = 6;
    localparam int PADDR_W           = 3;

    localparam logic [31:0] MIX_C1    = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2    = 32'hc2b2_ae35;
    localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_ADD   = 32'd12345;
    localparam logic [31:0] SYM_MIX   = 32'h045d_9f3b;
    localparam logic [15:0] SYM_BIAS  = 16'h8000;
    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(4);

    localparam logic [SYM_IDX_W-1:0] SYM_LAST = SYM_IDX_W'(SYMBOLS_PER_CHUNK - 1);

    // Register indexes
    localparam logic [PADDR_W-3:0] REG_BPC = '0;

    // Datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE  = 3'd0;
    localparam op_t OP_GOLD  = 3'd1;
    localparam op_t OP_MIX1  = 3'd2;
    localparam op_t OP_MIX2  = 3'd3;
    localparam op_t OP_SPINE = 3'd4;
    localparam op_t OP_LCG   = 3'd5;
    localparam op_t OP_MIXS  = 3'd6;

    typedef logic signed [15:0] sym_t;

    typedef struct packed {
        logic                 load;
        op_t                  op;
        logic [SYM_IDX_W-1:0] sym_idx;
        logic                 publish;
    } cmd_t;

    function automatic logic [31:0] chunk_mask(input logic [BPC_W-1:0] width);
        logic [31:0] mask;
        if (width == '0)
            mask = 32'h0000_0001;
        else if (width >= BPC_W'(32))
            mask = 32'hffff_ffff;
        else
            mask = (32'd1 << width[4:0]) - 32'd1;
        return mask;
    endfunction

endpackage

@@ rtl/sce_ctrl.sv @@
// Sequencer for the encoder: spine steps, then two multiply steps per symbol.
module sce_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output sce_pkg::cmd_t cmd
);
    import sce_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SPINE = 2'd1;
    localparam logic [1:0] ST_SYM   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           step_reg, step_next;
    logic [SYM_IDX_W-1:0] sym_reg, sym_next;
    logic                 phase_reg, phase_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sym_next       = sym_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sym_idx    = sym_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_SPINE;
                end
            end
            ST_SPINE:
            begin
                unique case (step_reg)
                    2'd0:    cmd.op = OP_GOLD;
                    2'd1:    cmd.op = OP_MIX1;
                    2'd2:    cmd.op = OP_MIX2;
                    default: cmd.op = OP_SPINE;
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    sym_next   = '0;
                    phase_next = 1'b0;
                    state_next = ST_SYM;
                end
            end
            ST_SYM:
            begin
                cmd.op     = phase_reg ? OP_MIXS : OP_LCG;
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (sym_reg == SYM_LAST)
                        state_next = ST_DONE;
                    else
                        sym_next = sym_reg + SYM_IDX_W'(1);
                end
            end
            default:
            begin
                // hold the finished beat until the output slot frees up
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sym_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sym_reg       <= sym_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/sce_datapath.sv @@
// Hash and symbol datapath built around one shared 32x32 multiplier.
module sce_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sce_pkg::cmd_t                 cmd,
    input  logic [31:0]                   message_bits,
    input  logic                          first_chunk,
    input  logic [sce_pkg::BPC_W-1:0]     bits_per_chunk,
    output sce_pkg::sym_t                 sym_out [sce_pkg::SYMBOL_SLOTS],
    output logic [31:0]                   spine_out
);
    import sce_pkg::*;

    logic [31:0] chunk_reg, prior_reg, gold_reg, acc_reg, spine_reg;
    logic [31:0] prev_spine_reg, prev_spine_next;
    sym_t        sym_reg     [SYMBOL_SLOTS];
    sym_t        out_sym_reg [SYMBOL_SLOTS];
    logic [31:0] out_spine_reg;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] h0, t_mix, t_spine, spine_new;

    assign h0        = prior_reg ^ chunk_reg;
    assign t_mix     = acc_reg + LCG_ADD;
    assign t_spine   = (acc_reg ^ (acc_reg >> 16)) + gold_reg;
    assign spine_new = t_spine ^ (t_spine >> 16);

    always_comb
    begin
        mul_a = acc_reg;
        mul_b = LCG_MUL;
        unique case (cmd.op)
            OP_GOLD:
            begin
                mul_a = chunk_reg;
                mul_b = GOLDEN;
            end
            OP_MIX1:
            begin
                mul_a = h0 ^ (h0 >> 16);
                mul_b = MIX_C1;
            end
            OP_MIX2:
            begin
                mul_a = acc_reg ^ (acc_reg >> 13);
                mul_b = MIX_C2;
            end
            OP_MIXS:
            begin
                mul_a = t_mix ^ (t_mix >> 16);
                mul_b = SYM_MIX;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = LCG_MUL;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        prev_spine_next = prev_spine_reg;
        if (cmd.op == OP_SPINE)
            prev_spine_next = spine_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_spine_reg <= '0;
        else
            prev_spine_reg <= prev_spine_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chunk_reg <= message_bits & chunk_mask(bits_per_chunk);
            prior_reg <= first_chunk ? 32'd0 : prev_spine_reg;
            for (int i = 0; i < SYMBOL_SLOTS; i++)
                sym_reg[i] <= '0;
        end
        unique case (cmd.op)
            OP_GOLD:  gold_reg <= prod;
            OP_SPINE:
            begin
                acc_reg   <= spine_new;
                spine_reg <= spine_new;
            end
            OP_MIXS:
            begin
                acc_reg              <= prod;
                sym_reg[cmd.sym_idx] <= sym_t'(prod[15:0] ^ SYM_BIAS);
            end
            OP_MIX1, OP_MIX2, OP_LCG: acc_reg <= prod;
            default: ;
        endcase
        if (cmd.publish)
        begin
            out_sym_reg   <= sym_reg;
            out_spine_reg <= spine_reg;
        end
    end

    assign sym_out   = out_sym_reg;
    assign spine_out = out_spine_reg;

endmodule

@@ rtl/spinal_code_encoder_core.sv @@
// Spinal code encoder: chunk hashing into a chained spine and symbol generation.
//
// Input channel (in_valid/in_ready) carries one chunk: message_bits, of which
// only the low bits_per_chunk bits are used (at least one, at most 32),
// and first_chunk, which restarts the spine chain at zero. Each accepted
// beat yields one output beat (out_valid/out_ready) with eight signed
// Q1.15 symbols and the new spine. All multiplies run through one shared
// 32x32 multiplier, at most one product a cycle: three hash multiplies for
// the spine, then the final mix without a multiply, and two multiplies per
// symbol. A new chunk is accepted only after the result of the previous
// one has been handed to the output register.
// The output register lets a new chunk be accepted while the previous result
// waits; if the receiver stalls, the finished result of the next chunk is
// held internally and no further chunk is accepted.
// Reset clears the spine chain to zero, sets bits_per_chunk to 4 and empties
// the output. bits_per_chunk is written over the APB port at address 0 and
// should only be changed while the block is idle.
module spinal_code_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sce_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   message_bits,
    input  logic                          first_chunk,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            symbol_0,
    output logic signed [15:0]            symbol_1,
    output logic signed [15:0]            symbol_2,
    output logic signed [15:0]            symbol_3,
    output logic signed [15:0]            symbol_4,
    output logic signed [15:0]            symbol_5,
    output logic signed [15:0]            symbol_6,
    output logic signed [15:0]            symbol_7,
    output logic [31:0]                   spine_value
);
    import sce_pkg::*;

    logic [BPC_W-1:0] bpc_reg, bpc_next;
    logic             reg_hit;
    cmd_t             cmd;
    sym_t             sym_out [SYMBOL_SLOTS];

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_BPC);
    assign prdata  = reg_hit ? {{(32-BPC_W){1'b0}}, bpc_reg} : 32'd0;

    always_comb
    begin
        bpc_next = bpc_reg;
        if (psel && penable && pwrite && reg_hit)
            bpc_next = pwdata[BPC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bpc_reg <= BPC_RESET;
        else
            bpc_reg <= bpc_next;
    end

    sce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sce_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .message_bits   (message_bits),
        .first_chunk    (first_chunk),
        .bits_per_chunk (bpc_reg),
        .sym_out        (sym_out),
        .spine_out      (spine_value)
    );

    assign symbol_0 = sym_out[0];
    assign symbol_1 = sym_out[1];
    assign symbol_2 = sym_out[2];
    assign symbol_3 = sym_out[3];
    assign symbol_4 = sym_out[4];
    assign symbol_5 = sym_out[5];
    assign symbol_6 = sym_out[6];
    assign symbol_7 = sym_out[7];

endmodule

@@ rtl/sce_checker.sv @@
// Port-level checks for the spinal code encoder, bound to the top level.
module sce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] symbol_0,
    input logic [31:0] spine_value
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(symbol_0) && $stable(spine_value))
        else $error("output beat changed while stalled");

    // the block is busy right after taking a chunk
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after accept");

    // a new result only appears while the block is busy with a chunk
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without work in progress");

endmodule

bind spinal_code_encoder_core sce_checker u_sce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol_0    (symbol_0),
    .spine_value (spine_value)
);
